// ----- hw/rtl/kvlp_pkg.sv -----
// Shared constants and helpers for the key/value line parser.
package kvlp_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KindValue = 2'd0;
	localparam kind_t KindEmpty = 2'd1;
	localparam kind_t KindEnd   = 2'd2;

	localparam logic [7:0] CharLf    = 8'd10;
	localparam logic [7:0] CharNul   = 8'd0;
	localparam logic [7:0] CharSpace = 8'd32;
	localparam logic [6:0] CharHash  = 7'h23;
	localparam logic [6:0] CharEq    = 7'h3d;
	localparam logic [6:0] CharColon = 7'h3a;
	localparam logic [6:0] CharSq    = 7'h27;
	localparam logic [6:0] CharDq    = 7'h22;

	localparam int MaxOut = 32;
	localparam logic [9:0] MaxEntriesReset = 10'd100;

	function automatic logic is_quote(input logic [6:0] c);
		is_quote = (c == CharSq) || (c == CharDq);
	endfunction

endpackage

// ----- hw/rtl/kvlp_ifs.sv -----
// Valid/ready channel interfaces for text bytes and parsed items.
interface kvlp_in_if import kvlp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface

interface kvlp_out_if import kvlp_pkg::*; ();
	logic               valid;
	logic               ready;
	kind_t              item_kind;
	logic [6:0]         value_byte;
	logic signed [31:0] key_hash;
	logic [9:0]         entry_index;
	logic               last_of_run;
	modport source(output valid, output item_kind, output value_byte, output key_hash,
		output entry_index, output last_of_run, input ready);
	modport sink(input valid, input item_kind, input value_byte, input key_hash,
		input entry_index, input last_of_run, output ready);
endinterface

// ----- hw/rtl/key_value_line_parser.sv -----
// Key/value line parser: buffers a text row, then splits, hashes and emits entries.
// Usage: an ordinary text byte is taken while the parser is idle. A line feed or
// zero byte closes the row; if the row holds '=' or ':', it starts a sequencer that
// walks the row store through its single read port, one position per cycle unless
// the output stalls: comment check, key trim, key hash (h*31+c by shift and
// subtract), value trim, quote check, then emission of the value items, during
// which text.ready is low. A finished item waits in the output register.
module key_value_line_parser import kvlp_pkg::*; #(
	parameter int ROW_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	kvlp_in_if.sink     text,
	kvlp_out_if.source  result
);

	localparam int AW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int CW = $clog2(ROW_BYTES + 1);
	localparam logic [CW-1:0] RowMax = CW'(ROW_BYTES);
	localparam logic [5:0] EmitCap = 6'(MaxOut - 2);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HCHK  = 4'd1;
	localparam logic [3:0] S_KS    = 4'd2;
	localparam logic [3:0] S_KE    = 4'd3;
	localparam logic [3:0] S_HASH  = 4'd4;
	localparam logic [3:0] S_VS    = 4'd5;
	localparam logic [3:0] S_VE    = 4'd6;
	localparam logic [3:0] S_QA    = 4'd7;
	localparam logic [3:0] S_QB    = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;
	localparam logic [3:0] S_EMPTY = 4'd10;
	localparam logic [3:0] S_INC   = 4'd11;
	localparam logic [3:0] S_TAIL  = 4'd12;

	logic [6:0] mem [ROW_BYTES];
	logic [6:0] rdata_q;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] len_q, eq_pos_q, col_pos_q;
	logic          eq_seen_q, col_seen_q;
	logic [CW-1:0] len_w_q, split_q, ks_q, ke_q, vs_q, ve_q;
	logic          zero_q, entry_q, first_quote_q, stopped_q;
	logic [9:0]    cnt_q, max_q;
	logic [31:0]   hash_q;
	logic [5:0]    n_q;

	logic          out_valid_q;
	kind_t         kind_q;
	logic [6:0]    value_q;
	logic [31:0]   out_hash_q;
	logic [9:0]    idx_q;
	logic          last_q;

	logic          in_acc, is_close, is_keep, out_free, out_load;
	kind_t         ld_kind;
	logic          ld_last;
	logic          blank, ks_more, ke_more, vs_more, ve_more, hash_last, emit_last;
	logic          strip;
	logic [CW-1:0] span, vs_n, ve_n;
	logic [9:0]    cnt_inc, m_eff;
	logic          end_after, need_end, row_ok;
	logic [6:0]    b7;

	assign text.ready         = (state_q == S_IDLE);
	assign in_acc             = text.valid && text.ready;
	assign is_close           = (text.text_byte == CharLf) || (text.text_byte == CharNul);
	assign b7                 = text.text_byte[6:0];
	assign is_keep            = !text.text_byte[7] && (text.text_byte >= CharSpace)
		&& (len_q < RowMax);
	assign row_ok             = (eq_seen_q || col_seen_q) && (len_q != '0);

	assign result.valid       = out_valid_q;
	assign result.item_kind   = kind_q;
	assign result.value_byte  = value_q;
	assign result.key_hash    = out_hash_q;
	assign result.entry_index = idx_q;
	assign result.last_of_run = last_q;
	assign out_free           = !out_valid_q || result.ready;

	assign blank     = (rdata_q <= 7'd32);
	assign ks_more   = (ptr_q < split_q) && blank;
	assign ke_more   = (ke_q > ks_q) && blank;
	assign vs_more   = (ptr_q < len_w_q) && blank;
	assign ve_more   = (ve_q > vs_q) && blank;
	assign hash_last = (ptr_q == ke_q - 1'b1);
	assign emit_last = (ptr_q == ve_q - 1'b1) || (n_q == EmitCap);
	assign strip     = first_quote_q && is_quote(rdata_q);
	assign span      = ve_q - vs_q;
	assign vs_n      = strip ? ((span >= CW'(2)) ? vs_q + 1'b1 : ve_q) : vs_q;
	assign ve_n      = (strip && (span >= CW'(2))) ? ve_q - 1'b1 : ve_q;
	assign cnt_inc   = cnt_q + 10'd1;
	assign m_eff     = (max_q == '0) ? 10'd1 : max_q;
	assign end_after = zero_q || (cnt_inc >= m_eff);
	assign need_end  = zero_q || (entry_q && (cnt_q >= m_eff));

	always_comb begin
		state_d  = state_q;
		ptr_d    = ptr_q;
		out_load = 1'b0;
		ld_kind  = KindValue;
		ld_last  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && !stopped_q && is_close) begin
					if (row_ok) begin
						state_d = S_HCHK;
						ptr_d   = '0;
					end else begin
						state_d = S_TAIL;
					end
				end
			end
			S_HCHK: state_d = (rdata_q == CharHash) ? S_TAIL : S_KS;
			S_KS: begin
				if (ks_more) begin
					ptr_d = ptr_q + 1'b1;
				end else begin
					state_d = S_KE;
					ptr_d   = split_q - 1'b1;
				end
			end
			S_KE: begin
				if (ke_more) begin
					ptr_d = ptr_q - 1'b1;
				end else if (ke_q == ks_q) begin
					state_d = S_TAIL;
				end else begin
					state_d = S_HASH;
					ptr_d   = ks_q;
				end
			end
			S_HASH: begin
				if (hash_last) begin
					state_d = S_VS;
					ptr_d   = split_q + 1'b1;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			S_VS: begin
				if (vs_more) begin
					ptr_d = ptr_q + 1'b1;
				end else begin
					state_d = S_VE;
					ptr_d   = len_w_q - 1'b1;
				end
			end
			S_VE: begin
				if (ve_more) begin
					ptr_d = ptr_q - 1'b1;
				end else if (ve_q > vs_q) begin
					state_d = S_QA;
					ptr_d   = vs_q;
				end else begin
					state_d = S_EMPTY;
				end
			end
			S_QA: begin
				state_d = S_QB;
				ptr_d   = ve_q - 1'b1;
			end
			S_QB: begin
				if (vs_n == ve_n) begin
					state_d = S_EMPTY;
				end else begin
					state_d = S_EMIT;
					ptr_d   = vs_n;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_kind  = KindValue;
					ld_last  = emit_last && !end_after;
					if (emit_last) begin
						state_d = S_INC;
					end else begin
						ptr_d = ptr_q + 1'b1;
					end
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_kind  = KindEmpty;
					ld_last  = !end_after;
					state_d  = S_INC;
				end
			end
			S_INC: state_d = S_TAIL;
			S_TAIL: begin
				if (!need_end) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					ld_kind  = KindEnd;
					ld_last  = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// row store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && !stopped_q && !is_close && is_keep) begin
			mem[len_q[AW-1:0]] <= b7;
		end
		rdata_q <= mem[ptr_d[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			len_q       <= '0;
			eq_pos_q    <= '0;
			col_pos_q   <= '0;
			eq_seen_q   <= 1'b0;
			col_seen_q  <= 1'b0;
			cnt_q       <= '0;
			stopped_q   <= 1'b0;
			max_q       <= MaxEntriesReset;
			zero_q      <= 1'b0;
			entry_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (stopped_q) begin
							if (text.text_byte == CharNul) begin
								len_q      <= '0;
								eq_seen_q  <= 1'b0;
								col_seen_q <= 1'b0;
								cnt_q      <= '0;
								stopped_q  <= 1'b0;
							end
						end else if (is_close) begin
							zero_q     <= (text.text_byte == CharNul);
							entry_q    <= 1'b0;
							len_q      <= '0;
							eq_seen_q  <= 1'b0;
							col_seen_q <= 1'b0;
						end else if (is_keep) begin
							len_q <= len_q + 1'b1;
							if (b7 == CharEq) begin
								eq_pos_q  <= len_q;
								eq_seen_q <= 1'b1;
							end
							if (b7 == CharColon) begin
								col_pos_q  <= len_q;
								col_seen_q <= 1'b1;
							end
						end
					end
				end
				S_INC: begin
					cnt_q   <= cnt_inc;
					entry_q <= 1'b1;
				end
				S_TAIL: begin
					if (out_load) begin
						if (zero_q) begin
							cnt_q     <= '0;
							stopped_q <= 1'b0;
						end else begin
							stopped_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers of the row walk
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				len_w_q <= len_q;
				split_q <= eq_seen_q ? eq_pos_q : col_pos_q;
			end
			S_KS: begin
				if (!ks_more) begin
					ks_q <= ptr_q;
					ke_q <= split_q;
				end
			end
			S_KE: begin
				if (ke_more) begin
					ke_q <= ke_q - 1'b1;
				end
				hash_q <= '0;
			end
			S_HASH: hash_q <= (hash_q << 5) - hash_q + {25'd0, rdata_q};
			S_VS: begin
				if (!vs_more) begin
					vs_q <= ptr_q;
					ve_q <= len_w_q;
				end
			end
			S_VE: begin
				if (ve_more) begin
					ve_q <= ve_q - 1'b1;
				end
			end
			S_QA: first_quote_q <= is_quote(rdata_q);
			S_QB: begin
				vs_q <= vs_n;
				ve_q <= ve_n;
				n_q  <= '0;
			end
			S_EMIT: begin
				if (out_free) begin
					n_q <= n_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			kind_q     <= ld_kind;
			last_q     <= ld_last;
			value_q    <= (ld_kind == KindValue) ? rdata_q : 7'd0;
			out_hash_q <= (ld_kind == KindEnd) ? 32'd0 : hash_q;
			idx_q      <= cnt_q;
		end
	end

endmodule
